// ===== hw/rtl/polyline_voxel_density_accumulator_assert.svh =====
// Assertion macros used by the checker file of the density accumulator.
// Depends on nothing; include by bare file name.
`ifndef POLYLINE_VOXEL_DENSITY_ACCUMULATOR_ASSERT_SVH
`define POLYLINE_VOXEL_DENSITY_ACCUMULATOR_ASSERT_SVH

// Checked at every edge outside reset.
`define PVDA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PVDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pvda_pkg.sv =====
// Package for the polyline voxel density accumulator: volume sizes, opcodes,
// register reset values and divider types. No dependencies.
package pvda_pkg;

  localparam int VOL_X             = 128;
  localparam int VOL_Y             = 128;
  localparam int VOL_Z             = 64;
  localparam int MAX_SEGMENT_STEPS = 1024;
  localparam int COUNT_BITS        = 16;

  localparam int STORE_SIZE = VOL_X * VOL_Y * VOL_Z;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CX_W       = (VOL_X > 1) ? $clog2(VOL_X) : 1;
  localparam int CY_W       = (VOL_Y > 1) ? $clog2(VOL_Y) : 1;
  localparam int CZ_W       = (VOL_Z > 1) ? $clog2(VOL_Z) : 1;
  localparam int STEP_W     = $clog2(MAX_SEGMENT_STEPS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Fixed-point widths.
  localparam int ACC_W = 48;   // Q.30 accumulators for secondary axes
  localparam int SUM_W = 60;   // Q.24 matrix row sums
  localparam int VOX_W = SUM_W - 24;

  // Divider: |num| << 30 / den, quotient never above 2^30. A coordinate
  // difference needs 33 bits of magnitude.
  localparam int DIV_W = 33;
  localparam int QUO_W = 31;
  localparam int CNT_W = $clog2(QUO_W);

  localparam int NUM_CFG = 6;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  localparam logic [CFG_W-1:0] CFG_RST_0 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] CFG_RST_1 = 64'h0;
  localparam logic [CFG_W-1:0] CFG_RST_2 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] CFG_RST_3 = 64'h0;
  localparam logic [CFG_W-1:0] CFG_RST_4 = 64'h0;
  localparam logic [CFG_W-1:0] CFG_RST_5 = 64'h0000_0000_0001_0000;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/pvda_div.sv =====
// Restoring divider for segment slopes, one quotient bit per cycle.
// Depends on pvda_pkg.
module pvda_div import pvda_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num_mag,
  input  logic [DIV_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output div_stat_t        stat
);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             ge;
  logic [DIV_W:0]   diff;

  // The numerator never exceeds the divisor, so the partial remainder
  // stays below twice the divisor.
  assign ge   = rem >= {1'b0, den_r};
  assign diff = ge ? rem - {1'b0, den_r} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem       <= {1'b0, num_mag};
        den_r     <= den;
        quo       <= '0;
        cnt       <= CNT_W'(QUO_W - 1);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        quo <= {quo[QUO_W-2:0], ge};
        rem <= {diff[DIV_W-1:0], 1'b0};
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/polyline_voxel_density_accumulator.sv =====
// Polyline voxel density accumulator: DDA walk of polyline segments into a
// saturating voxel histogram held in one synchronous memory.
// Depends on pvda_pkg and pvda_div.
// A read passes the registered memory read port; a point that starts a path
// only records the point. A segment runs two slope divisions, then per sample
// one shared multiplier over nine terms and a read-modify-write for a new voxel.
// Clear writes all VOL_X*VOL_Y*VOL_Z entries (1048576), one memory entry per cycle.
// Reset starts the same clearing pass; in_ready stays low until it ends.
module polyline_voxel_density_accumulator import pvda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic                starts_path,
  input  logic [6:0]          read_x,
  input  logic [6:0]          read_y,
  input  logic [5:0]          read_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         voxel_count,
  output logic [10:0]         voxels_marked,
  output logic                hit_outside,
  output logic                segment_cut,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_SETUP  = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_DIVW   = 4'd4;
  localparam logic [3:0] ST_LOOP   = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_ROUND  = 4'd7;
  localparam logic [3:0] ST_CHECK  = 4'd8;
  localparam logic [3:0] ST_RMW    = 4'd9;
  localparam logic [3:0] ST_ADV    = 4'd10;
  localparam logic [3:0] ST_RDREQ  = 4'd11;
  localparam logic [3:0] ST_RDDONE = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  // Configuration registers: two Q15.16 matrix entries each.
  logic [CFG_W-1:0] cfg [NUM_CFG];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0] <= CFG_RST_0;
      cfg[1] <= CFG_RST_1;
      cfg[2] <= CFG_RST_2;
      cfg[3] <= CFG_RST_3;
      cfg[4] <= CFG_RST_4;
      cfg[5] <= CFG_RST_5;
    end else if (cfg_we && (int'(cfg_index) < NUM_CFG)) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // Histogram memory: one write port and one registered read port.
  logic [COUNT_BITS-1:0] mem [STORE_SIZE];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [COUNT_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  logic [3:0]               state;
  logic signed [31:0]       prev   [3];
  logic signed [31:0]       seg_a  [3];
  logic signed [31:0]       seg_b  [3];
  logic signed [31:0]       lo     [3];
  logic [DIV_W-1:0]         mag_r  [3];
  logic [2:0]               d_neg;
  logic [1:0]               ax;
  logic                     swap;
  logic signed [31:0]       hi_ax;
  logic [DIV_W-1:0]         den_r;
  logic signed [31:0]       slope  [3];
  logic signed [ACC_W-1:0]  acc    [3];
  logic signed [31:0]       m;
  logic [STEP_W-1:0]        n;
  logic [STEP_W-1:0]        marked;
  logic                     wk_outside;
  logic                     wk_cut;
  logic [15:0]              wk_count;
  logic signed [31:0]       pm     [3];
  logic [1:0]               mr;
  logic [1:0]               mc;
  logic [1:0]               prod_row;
  logic                     mul_go;
  logic                     prod_vld;
  logic signed [63:0]       prod;
  logic signed [SUM_W-1:0]  sum    [3];
  logic [ADDR_W-1:0]        vox_idx;
  logic                     vox_out;
  logic [ADDR_W-1:0]        last_voxel;
  logic                     last_valid;
  logic [ADDR_W-1:0]        rq_addr;
  logic                     rq_ok;
  logic [ADDR_W-1:0]        clr_addr;
  logic                     clr_reply;
  logic [1:0]               div_i;

  assign in_ready = (state == ST_IDLE);

  // Segment setup: differences, dominant axis and walk direction.
  logic signed [32:0] dc [3];
  logic [32:0]        mg [3];
  logic [1:0]         ax_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dc[i] = {seg_b[i][31], seg_b[i]} - {seg_a[i][31], seg_a[i]};
      mg[i] = dc[i][32] ? 33'(-dc[i]) : 33'(dc[i]);
    end
    if (mg[0] >= mg[1] && mg[0] >= mg[2]) begin
      ax_c = 2'd0;
    end else if (mg[1] >= mg[2]) begin
      ax_c = 2'd1;
    end else begin
      ax_c = 2'd2;
    end
  end

  // Slope divider, shared by the two secondary axes.
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [QUO_W-1:0] div_quo;
  div_stat_t        div_stat;

  assign div_start = (state == ST_DIV) && (div_i != 2'd3) && (div_i != ax);

  always_comb begin
    case (div_i)
      2'd0:    div_num = mag_r[0];
      2'd1:    div_num = mag_r[1];
      2'd2:    div_num = mag_r[2];
      default: div_num = '0;
    endcase
  end

  pvda_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_mag (div_num),
    .den     (den_r),
    .quo     (div_quo),
    .stat    (div_stat)
  );

  logic signed [31:0] quo_s;
  assign quo_s = {1'b0, div_quo};

  // Matrix term: one coefficient times one sample coordinate per cycle.
  logic signed [31:0]      coef;
  logic [CFG_W-1:0]        coef_reg;
  logic signed [SUM_W-1:0] term;

  assign coef_reg = cfg[{mr, mc[1]}];
  assign coef     = mc[0] ? coef_reg[63:32] : coef_reg[31:0];
  assign term     = SUM_W'(prod >>> 8);

  // Rounding to voxel indices and the volume check.
  logic signed [VOX_W-1:0] v [3];
  logic                    outside_c;
  logic [ADDR_W-1:0]       idx_c;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      v[r] = VOX_W'((sum[r] + (SUM_W'(1) <<< 23)) >>> 24);
    end
    outside_c = (v[0] < 0) || (v[0] >= VOL_X) ||
                (v[1] < 0) || (v[1] >= VOL_Y) ||
                (v[2] < 0) || (v[2] >= VOL_Z);
    idx_c = ADDR_W'(v[0][CX_W-1:0]) + ADDR_W'(VOL_X) *
            (ADDR_W'(v[1][CY_W-1:0]) + ADDR_W'(VOL_Y) * ADDR_W'(v[2][CZ_W-1:0]));
  end

  logic [COUNT_BITS-1:0] sat_inc;
  assign sat_inc = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

  // Memory port steering. Only one sample's read-modify-write is in flight,
  // and its write lands long before the next read, so no forwarding.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = vox_idx;
    mem_wdata = sat_inc;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_RMW) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state == ST_CHECK) ? idx_c : rq_addr;
  end

  logic signed [32:0] m_lim;
  assign m_lim = {hi_ax[31], hi_ax} - 33'sd65536;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      last_valid <= 1'b0;
      out_valid  <= 1'b0;
      mul_go     <= 1'b0;
      prod_vld   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else begin
      // The result register empties on its handshake unless a new beat
      // is loaded into it in the same cycle.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            marked     <= '0;
            wk_outside <= 1'b0;
            wk_cut     <= 1'b0;
            wk_count   <= '0;
            case (opcode)
              OP_ADD: begin
                prev[0] <= point_x;
                prev[1] <= point_y;
                prev[2] <= point_z;
                seg_a   <= prev;
                seg_b[0] <= point_x;
                seg_b[1] <= point_y;
                seg_b[2] <= point_z;
                state <= starts_path ? ST_DONE : ST_SETUP;
              end
              OP_READ: begin
                rq_ok   <= (int'(read_x) < VOL_X) && (int'(read_y) < VOL_Y) &&
                           (int'(read_z) < VOL_Z);
                rq_addr <= ADDR_W'(read_x) + ADDR_W'(VOL_X) *
                           (ADDR_W'(read_y) + ADDR_W'(VOL_Y) * ADDR_W'(read_z));
                state   <= ST_RDREQ;
              end
              OP_CLEAR: begin
                clr_addr   <= '0;
                clr_reply  <= 1'b1;
                last_valid <= 1'b0;
                state      <= ST_CLEAR;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
            state <= clr_reply ? ST_DONE : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_SETUP: begin
          ax    <= ax_c;
          swap  <= dc[ax_c][32];
          hi_ax <= dc[ax_c][32] ? seg_a[ax_c] : seg_b[ax_c];
          den_r <= mg[ax_c];
          for (int i = 0; i < 3; i++) begin
            lo[i]    <= dc[ax_c][32] ? seg_b[i] : seg_a[i];
            mag_r[i] <= mg[i];
            d_neg[i] <= dc[i][32];
          end
          div_i <= 2'd0;
          state <= (dc[ax_c] == '0) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (div_i == 2'd3) begin
            for (int i = 0; i < 3; i++) begin
              acc[i] <= {{(ACC_W-46){lo[i][31]}}, lo[i], 14'b0};
            end
            m     <= lo[ax];
            n     <= '0;
            state <= ST_LOOP;
          end else if (div_i == ax) begin
            div_i <= div_i + 1'b1;
          end else begin
            state <= ST_DIVW;
          end
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            slope[div_i] <= (d_neg[div_i] ^ swap) ? -quo_s : quo_s;
            div_i        <= div_i + 1'b1;
            state        <= ST_DIV;
          end
        end
        ST_LOOP: begin
          if (m >= hi_ax) begin
            state <= ST_DONE;
          end else if (n >= STEP_W'(MAX_SEGMENT_STEPS)) begin
            wk_cut <= 1'b1;
            state  <= ST_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              pm[i] <= (2'(i) == ax) ? m : acc[i][45:14];
              sum[i] <= {{(SUM_W-40){cfg[2*i+1][63]}}, cfg[2*i+1][63:32], 8'b0};
            end
            mr       <= 2'd0;
            mc       <= 2'd0;
            mul_go   <= 1'b1;
            prod_vld <= 1'b0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_go) begin
            prod     <= coef * pm[mc];
            prod_row <= mr;
            if (mc == 2'd2) begin
              mc <= 2'd0;
              mr <= mr + 1'b1;
              if (mr == 2'd2) begin
                mul_go <= 1'b0;
              end
            end else begin
              mc <= mc + 1'b1;
            end
          end
          prod_vld <= mul_go;
          if (prod_vld) begin
            sum[prod_row] <= sum[prod_row] + term;
          end
          if (!mul_go && !prod_vld) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          vox_out <= outside_c;
          vox_idx <= idx_c;
          state   <= ST_CHECK;
        end
        ST_CHECK: begin
          // The read address is steered here from the same rounding logic.
          if (vox_out) begin
            wk_outside <= 1'b1;
            last_valid <= 1'b0;
            state      <= ST_ADV;
          end else if (last_valid && last_voxel == vox_idx) begin
            state <= ST_ADV;
          end else begin
            last_voxel <= vox_idx;
            last_valid <= 1'b1;
            state      <= ST_RMW;
          end
        end
        ST_RMW: begin
          marked <= marked + 1'b1;
          state  <= ST_ADV;
        end
        ST_ADV: begin
          n <= n + 1'b1;
          if ($signed({m[31], m}) > m_lim) begin
            m <= hi_ax;
          end else begin
            m <= m + 32'sd65536;
          end
          for (int i = 0; i < 3; i++) begin
            if (2'(i) != ax) begin
              acc[i] <= acc[i] + {{(ACC_W-32){slope[i][31]}}, slope[i]};
            end
          end
          state <= ST_LOOP;
        end
        ST_RDREQ: begin
          state <= ST_RDDONE;
        end
        ST_RDDONE: begin
          wk_count <= rq_ok ? 16'(rd_data) : 16'd0;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            voxel_count   <= wk_count;
            voxels_marked <= 11'(marked);
            hit_outside   <= wk_outside;
            segment_cut   <= wk_cut;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pvda_checker.sv =====
// Port-level checker for the density accumulator, bound to the top level.
// Depends on pvda_pkg and the assertion macro header.
`include "polyline_voxel_density_accumulator_assert.svh"

module pvda_checker import pvda_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] voxel_count,
  input logic [10:0] voxels_marked,
  input logic        hit_outside,
  input logic        segment_cut
);

  // A result held back by the consumer keeps its voxel count and marked total.
  `PVDA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(voxel_count) && $stable(voxels_marked), "stalled result changed")

  // The block works on one beat at a time.
  `PVDA_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // Reset starts the clearing pass, so no beat is taken right after it.
  `PVDA_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !in_ready, "input ready during clearing")

  // A read result never carries segment statistics.
  `PVDA_ASSERT(a_read_vs_walk, clk, rst, out_valid && voxel_count != 16'd0 |-> voxels_marked == 11'd0 && !hit_outside && !segment_cut, "mixed result fields")

endmodule

bind polyline_voxel_density_accumulator pvda_checker u_pvda_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for polyline_voxel_density_accumulator.
// Depends on pvda_pkg and the block's RTL; a built-in voxel walk model
// predicts every result beat, which a checker process compares in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pvda_pkg::*;

  // Configuration register indexes, in the order the block defines them.
  localparam logic [CIDX_W-1:0] REG_ROW0_A = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ROW0_B = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ROW1_A = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ROW1_B = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ROW2_A = 3'd4;
  localparam logic [CIDX_W-1:0] REG_ROW2_B = 3'd5;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Reset and every clear walk the whole store once, so the limit is
  // dominated by those passes plus the truncated long segments.
  localparam longint LIMIT_CYCLES = 20_000_000;
  localparam int ONE = 65536;

  typedef struct packed {
    logic [15:0] count;
    logic [10:0] marked;
    logic        outside;
    logic        cut;
  } voxel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic starts_path = 1'b0;
  logic [6:0] read_x = '0, read_y = '0;
  logic [5:0] read_z = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [15:0] voxel_count;
  logic [10:0] voxels_marked;
  logic hit_outside, segment_cut;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  polyline_voxel_density_accumulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .starts_path(starts_path), .read_x(read_x), .read_y(read_y), .read_z(read_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .voxel_count(voxel_count), .voxels_marked(voxels_marked),
    .hit_outside(hit_outside), .segment_cut(segment_cut),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor state: a shadow of the matrix, a sparse copy of the density
  // histogram (a missing entry reads as zero), the previous polyline point
  // and the last voxel marked.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] matrix_regs [NUM_CFG];
  logic [15:0] density [int];
  longint prev_pt [3];
  int last_vox;
  bit last_vox_ok;

  voxel_result_t pending_results [$];
  int errors = 0;
  bit gaps_on = 1'b1;
  bit hold_start = 1'b0;
  int hold_cnt = 0;
  int stall_cnt = 0;

  // World cursor the random polylines wander from, Q15.16.
  longint cur_x, cur_y, cur_z;

  function automatic longint matrix_entry(int k);
    logic [CFG_W-1:0] r;
    r = matrix_regs[k >> 1];
    return (k & 1) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Maps one sample through the matrix and marks its voxel.
  // Returns 1 when marked, 0 when it repeats the last voxel, -1 when outside.
  function automatic int mark_sample(longint p [3]);
    longint v [3];
    longint dims [3];
    longint s;
    int idx;
    dims[0] = VOL_X; dims[1] = VOL_Y; dims[2] = VOL_Z;
    for (int r = 0; r < 3; r++) begin
      s = matrix_entry(4 * r + 3) * 256;
      for (int c = 0; c < 3; c++)
        s += (matrix_entry(4 * r + c) * p[c]) >>> 8;
      v[r] = (s + (longint'(1) << 23)) >>> 24;   // round half up
    end
    for (int r = 0; r < 3; r++) begin
      if (v[r] < 0 || v[r] >= dims[r]) begin
        last_vox_ok = 1'b0;
        return -1;
      end
    end
    idx = int'(v[0] + VOL_X * (v[1] + VOL_Y * v[2]));
    if (last_vox_ok && last_vox == idx)
      return 0;
    last_vox = idx;
    last_vox_ok = 1'b1;
    if (!density.exists(idx))
      density[idx] = '0;
    if (density[idx] != COUNT_MAX)
      density[idx] = density[idx] + 1'b1;
    return 1;
  endfunction

  // Walks one segment along its dominant axis from the lower end.
  function automatic void walk_segment(longint a [3], longint b [3],
                                       ref voxel_result_t res);
    longint d [3], lo [3], hi [3], acc [3], slope [3], p [3];
    longint m, num;
    longint unsigned den, q;
    int ax, n, marked, st;
    bit outside, cut;
    n = 0; marked = 0; outside = 0; cut = 0;
    for (int i = 0; i < 3; i++)
      d[i] = b[i] - a[i];
    if (mag(d[0]) >= mag(d[1]) && mag(d[0]) >= mag(d[2]))
      ax = 0;
    else if (mag(d[1]) >= mag(d[2]))
      ax = 1;
    else
      ax = 2;
    if (a[ax] > b[ax]) begin
      lo = b; hi = a;
    end else begin
      lo = a; hi = b;
    end
    if (hi[ax] > lo[ax]) begin
      den = longint'(hi[ax] - lo[ax]);
      for (int i = 0; i < 3; i++) begin
        num = hi[i] - lo[i];
        q = (longint'(mag(num)) << 30) / den;
        slope[i] = (num < 0) ? -longint'(q) : longint'(q);
        acc[i] = lo[i] * 16384;
      end
      m = lo[ax];
      while (m < hi[ax]) begin
        if (n >= MAX_SEGMENT_STEPS) begin
          cut = 1'b1;
          break;
        end
        for (int i = 0; i < 3; i++)
          p[i] = (i == ax) ? m : (acc[i] >>> 14);
        st = mark_sample(p);
        if (st > 0)
          marked++;
        else if (st < 0)
          outside = 1'b1;
        n++;
        if (m > hi[ax] - ONE)
          m = hi[ax];
        else
          m += ONE;
        for (int i = 0; i < 3; i++)
          if (i != ax)
            acc[i] += slope[i];
      end
    end
    res.marked = marked[10:0];
    res.outside = outside;
    res.cut = cut;
  endfunction

  function automatic voxel_result_t predict_voxel_result(
      logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic sp, logic [6:0] rx, logic [6:0] ry,
      logic [5:0] rz);
    voxel_result_t res;
    longint pt [3];
    int idx;
    res = '0;
    case (op)
      OP_ADD: begin
        pt[0] = x; pt[1] = y; pt[2] = z;
        if (!sp)
          walk_segment(prev_pt, pt, res);
        prev_pt = pt;
      end
      OP_READ: begin
        idx = int'(rx) + VOL_X * (int'(ry) + VOL_Y * int'(rz));
        if (rx < VOL_X && ry < VOL_Y && rz < VOL_Z && density.exists(idx))
          res.count = density[idx];
      end
      OP_CLEAR: begin
        density.delete();
        last_vox_ok = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; the handshake is judged on
  // the values seen at the rising edge.
  // ---------------------------------------------------------------------
  task automatic send_item(logic [1:0] op, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z,
                           logic sp, logic [6:0] rx, logic [6:0] ry,
                           logic [5:0] rz);
    opcode = op; point_x = x; point_y = y; point_z = z;
    starts_path = sp; read_x = rx; read_y = ry; read_z = rz;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready)
        break;
    end
    pending_results.push_back(predict_voxel_result(op, x, y, z, sp, rx, ry, rz));
    @(negedge clk);
    in_valid = 1'b0;
    if (gaps_on && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  task automatic send_point(longint x, longint y, longint z, logic sp);
    send_item(OP_ADD, x[31:0], y[31:0], z[31:0], sp,
              $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63));
  endtask

  task automatic send_read(int rx, int ry, int rz);
    send_item(OP_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1),
              rx[6:0], ry[6:0], rz[5:0]);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    matrix_regs[idx] = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_matrix(logic [CFG_W-1:0] r0a, logic [CFG_W-1:0] r0b,
                              logic [CFG_W-1:0] r1a, logic [CFG_W-1:0] r1b,
                              logic [CFG_W-1:0] r2a, logic [CFG_W-1:0] r2b);
    write_reg(REG_ROW0_A, r0a);
    write_reg(REG_ROW0_B, r0b);
    write_reg(REG_ROW1_A, r1a);
    write_reg(REG_ROW1_B, r1b);
    write_reg(REG_ROW2_A, r2a);
    write_reg(REG_ROW2_B, r2b);
  endtask

  // Sender stops until every expected beat has been seen.
  task automatic wait_drained();
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Keeps a world coordinate near the volume by reflecting the step.
  function automatic longint bounce(longint c, longint step, int top);
    longint n;
    n = c + step;
    if (n < -4 * ONE || n > longint'(top + 4) * ONE)
      n = c - step;
    return n;
  endfunction

  // One random beat. Most are short well-formed polyline steps from the
  // cursor, with reads aimed near the cursor; the rest are jumps, random
  // reads, the unused opcode, full-range noise points and medium segments.
  task automatic send_random_item();
    int r, span, rx, ry, rz;
    longint nx, ny, nz;
    r = $urandom_range(0, 99);
    if (r < 68) begin
      span = ($urandom_range(0, 24) == 0) ? 64 * ONE : 8 * ONE;
      nx = bounce(cur_x, longint'($urandom_range(0, 2 * span)) - span, VOL_X);
      ny = bounce(cur_y, longint'($urandom_range(0, 2 * span)) - span, VOL_Y);
      nz = bounce(cur_z, longint'($urandom_range(0, 2 * span)) - span, VOL_Z);
      send_point(nx, ny, nz, 1'b0);
      cur_x = nx; cur_y = ny; cur_z = nz;
    end else if (r < 73) begin
      cur_x = $urandom_range(0, VOL_X * ONE);
      cur_y = $urandom_range(0, VOL_Y * ONE);
      cur_z = $urandom_range(0, VOL_Z * ONE);
      send_point(cur_x, cur_y, cur_z, $urandom_range(0, 3) != 0);
    end else if (r < 88) begin
      if ($urandom_range(0, 1)) begin
        rx = int'((cur_x + ONE / 2) >>> 16) + $urandom_range(0, 2) - 1;
        ry = int'((cur_y + ONE / 2) >>> 16) + $urandom_range(0, 2) - 1;
        rz = int'((cur_z + ONE / 2) >>> 16) + $urandom_range(0, 2) - 1;
        rx = (rx < 0) ? 0 : (rx > VOL_X - 1) ? VOL_X - 1 : rx;
        ry = (ry < 0) ? 0 : (ry > VOL_Y - 1) ? VOL_Y - 1 : ry;
        rz = (rz < 0) ? 0 : (rz > VOL_Z - 1) ? VOL_Z - 1 : rz;
        send_read(rx, ry, rz);
      end else begin
        send_read($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63));
      end
    end else if (r < 91) begin
      send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63));
    end else if (r < 93) begin
      // Full-range point: the segment to it, when drawn, and the one back, are truncated.
      send_item(OP_ADD, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63));
    end else begin
      cur_x = $urandom_range(0, VOL_X * ONE);
      cur_y = $urandom_range(0, VOL_Y * ONE);
      cur_z = $urandom_range(0, VOL_Z * ONE);
      send_point(cur_x, cur_y, cur_z, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else if (!gaps_on) begin
      out_ready = 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(0, 9) == 0)
        stall_cnt = $urandom_range(1, 18);
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    voxel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: count=%0d marked=%0d out=%0b cut=%0b",
                   voxel_count, voxels_marked, hit_outside, segment_cut);
      end else begin
        want = pending_results.pop_front();
        if (voxel_count !== want.count || voxels_marked !== want.marked ||
            hit_outside !== want.outside || segment_cut !== want.cut) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected count=%0d marked=%0d out=%0b cut=%0b, got count=%0d marked=%0d out=%0b cut=%0b",
                     want.count, want.marked, want.outside, want.cut,
                     voxel_count, voxels_marked, hit_outside, segment_cut);
        end
      end
    end
  end

  // Watchdog.
  longint cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Edge cases at the reset matrix (identity, zero offsets).
  task automatic test_directed();
    send_read(0, 0, 0);
    send_read(127, 127, 63);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              7'h7F, 7'h7F, 6'h3F);
    // First point with no path start draws from the origin.
    send_point(5 * ONE + ONE / 2, 3 * ONE + ONE / 4, 2 * ONE, 1'b0);
    send_read(0, 0, 1);
    send_point(10 * ONE, 10 * ONE, 10 * ONE, 1'b1);
    send_point(10 * ONE, 10 * ONE, 10 * ONE, 1'b0);    // zero length
    send_point(13 * ONE, 10 * ONE, 10 * ONE, 1'b0);    // marks x 10..12
    send_point(16 * ONE, 10 * ONE, 10 * ONE, 1'b0);    // marks x 13..15
    send_point(15 * ONE, 10 * ONE, 10 * ONE, 1'b0);    // repeats voxel 15
    send_read(15, 10, 11);
    // A descending y-dominant and an ascending z-dominant segment with fractional slopes.
    send_point(15 * ONE, 2 * ONE + 777, 7 * ONE, 1'b0);
    send_point(16 * ONE + 12345, 3 * ONE, 40 * ONE, 1'b0);
    // Crossing the volume boundary.
    send_point(-5 * ONE, 3 * ONE, 40 * ONE, 1'b0);
    send_point(3 * ONE, 3 * ONE, 70 * ONE, 1'b0);
    // Overlong segment and the extremes of the point fields.
    send_point(0, 0, 0, 1'b1);
    send_point(2000 * ONE, 0, 0, 1'b0);
    send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
              7'h00, 7'h00, 6'h00);
    send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0,
              7'h7F, 7'h7F, 6'h3F);
    send_read(1, 0, 1);
    // Clear, then a read next to a voxel that was marked returns zero.
    send_item(OP_CLEAR, 0, 0, 0, 1'b0, 7'h00, 7'h00, 6'h00);
    send_read(12, 10, 11);
    send_point(20 * ONE, 20 * ONE, 20 * ONE, 1'b1);
    send_point(22 * ONE, 20 * ONE, 20 * ONE, 1'b0);
    send_read(20, 20, 21);
    wait_drained();
  endtask

  // Random polylines under one matrix setting.
  task automatic test_matrix_phase(logic [CFG_W-1:0] r0a, logic [CFG_W-1:0] r0b,
                                   logic [CFG_W-1:0] r1a, logic [CFG_W-1:0] r1b,
                                   logic [CFG_W-1:0] r2a, logic [CFG_W-1:0] r2b,
                                   int n_items);
    wait_drained();
    write_matrix(r0a, r0b, r1a, r1b, r2a, r2b);
    repeat (n_items) send_random_item();
  endtask

  // Output held off while reads keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_drained();
    hold_start = 1'b1;
    repeat (40)
      send_read($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63));
    wait_drained();
    repeat (20) send_random_item();
  endtask

  // Last stretch: both sides flat out.
  task automatic test_full_rate();
    wait_drained();
    gaps_on = 1'b0;
    repeat (150) send_random_item();
  endtask

  initial begin
    matrix_regs[0] = CFG_RST_0; matrix_regs[1] = CFG_RST_1;
    matrix_regs[2] = CFG_RST_2; matrix_regs[3] = CFG_RST_3;
    matrix_regs[4] = CFG_RST_4; matrix_regs[5] = CFG_RST_5;
    prev_pt[0] = 0; prev_pt[1] = 0; prev_pt[2] = 0;
    last_vox = 0;
    last_vox_ok = 1'b0;
    cur_x = 20 * ONE; cur_y = 20 * ONE; cur_z = 20 * ONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The clearing pass after reset holds in_ready low; wait it out.
    while (!in_ready)
      @(negedge clk);

    test_directed();
    // Identity with the reset offsets, written explicitly.
    test_matrix_phase(CFG_RST_0, CFG_RST_1, CFG_RST_2, CFG_RST_3, CFG_RST_4,
                      CFG_RST_5, 280);
    // Scaled, fractional and offset rows.
    test_matrix_phase({32'sh0000_8000, 32'sh0001_8000}, {32'sh0003_8000, 32'sh0000_0000},
                      {32'sh0000_4000, 32'sh0000_0000}, {32'sh0002_0000, 32'sh0000_8000},
                      {32'sh0000_0000, 32'sh0000_0000}, {32'sh0000_8000, 32'sh0000_8000},
                      280);
    // Mirrored axes with negative coefficients and large offsets.
    test_matrix_phase({32'shFFFF_0000, 32'sh0000_0000}, {32'sh007F_0000, 32'sh0000_0000},
                      {32'sh0000_0000, 32'shFFFF_0000}, {32'sh007F_0000, 32'sh0000_0000},
                      {32'shFFFF_8000, 32'sh0000_0000}, {32'sh003F_0000, 32'sh0000_0000},
                      280);
    // Zero matrix: every sample lands on voxel (0,0,0).
    test_matrix_phase('0, '0, '0, '0, '0, '0, 200);
    // All ones: every entry is minus one lsb.
    test_matrix_phase('1, '1, '1, '1, '1, '1, 200);
    // Most positive and most negative entries.
    test_matrix_phase({2{32'sh7FFF_FFFF}}, {2{32'sh8000_0000}}, {2{32'sh7FFF_FFFF}},
                      {2{32'sh8000_0000}}, {2{32'sh8000_0000}}, {2{32'sh7FFF_FFFF}},
                      120);
    // Fully random registers.
    test_matrix_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      120);
    // Back to a near-identity matrix for the rest.
    test_matrix_phase(CFG_RST_0, {32'sh0000_0000, 32'sh0000_4000}, CFG_RST_2,
                      CFG_RST_3, CFG_RST_4, CFG_RST_5, 200);
    test_backpressure();
    test_full_rate();

    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pvda_pkg.sv
hw/rtl/pvda_div.sv
hw/rtl/polyline_voxel_density_accumulator.sv
hw/rtl/pvda_checker.sv
verif/tb_top.sv
